// ----- design/scs_pkg.sv -----
`timescale 1ns / 1ps

package scs_pkg;

   // block sizing
   localparam int COUNT_DIGITS = 4;
   localparam int MOTOR_COUNT  = 3;
   localparam int COUNT_W      = 14;
   localparam int DELAY_W      = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // ascii codes
   localparam logic [7:0] ASCII_G    = 8'h67;
   localparam logic [7:0] ASCII_D    = 8'h64;
   localparam logic [7:0] ASCII_K    = 8'h6B;
   localparam logic [7:0] ASCII_ONE  = 8'h31;
   localparam logic [7:0] ASCII_TWO  = 8'h32;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   // configuration register indexes
   localparam logic [1:0] CSR_DELAY_G = 2'd0;
   localparam logic [1:0] CSR_DELAY_D = 2'd1;
   localparam logic [1:0] CSR_DELAY_K = 2'd2;

   // delay reset values
   localparam logic [DELAY_W-1:0] DELAY_G_RESET = 8'd18;
   localparam logic [DELAY_W-1:0] DELAY_D_RESET = 8'd2;
   localparam logic [DELAY_W-1:0] DELAY_K_RESET = 8'd2;

   localparam logic [7:0] PORT_CLEAR = 8'h00;

   typedef enum logic [1:0] {
      MOTOR_G = 2'd0,
      MOTOR_D = 2'd1,
      MOTOR_K = 2'd2
   } motor_type;

   // classified item passed from front to back
   typedef struct packed {
      logic                tick;
      motor_type           motor;
      logic                reverse;
      logic [COUNT_W-1:0]  count;
   } item_type;

   // per-motor hold times
   typedef struct packed {
      logic [DELAY_W-1:0] g;
      logic [DELAY_W-1:0] d;
      logic [DELAY_W-1:0] k;
   } delays_type;

   // full-step coil pattern by phase
   function automatic logic [3:0] step_base(input logic [1:0] phase);
      logic [3:0] pat;
      unique case (phase)
         2'd0: pat = 4'd3;
         2'd1: pat = 4'd6;
         2'd2: pat = 4'd12;
         default: pat = 4'd9;
      endcase
      return pat;
   endfunction

endpackage

// ----- design/stepper_command_sequencer.sv -----
`timescale 1ns / 1ps

// Full-step sequencer for three two-phase stepper motors (g, d, k).
// Request channel (req_*): each transfer is either a one-millisecond tick
// (req_command = 0) or a command packet with motor letter, direction
// character and four ASCII count digits. Unknown packets are dropped at
// the front; packets that arrive during a move are discarded.
// Response channel (rsp_*): one transfer per coil step or move end, giving
// the new port B and port A values; rsp_move_done marks the clearing result.
// Config channel (csr_*): per-motor step hold times in ticks, index 0..2;
// csr_ready is always high. Write only while no move is running.
// Path: a result passes through the queue entry register and then the
// output register before it is on rsp_*.
// Throughput: one request per cycle while req_stall is low; the front
// decodes into a two-entry queue; the back consumes one entry per cycle.
// When rsp_stall is high the result holds; requests that yield no result
// keep draining, and the queue filling up raises req_stall.
// Reset: phases, move state and ports clear, hold times return to
// 18, 2 and 2 ticks; no clearing pass is needed.
module stepper_command_sequencer import scs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_motor_letter,
   input  logic [7:0]  req_direction_char,
   input  logic [7:0]  req_digit_thousands,
   input  logic [7:0]  req_digit_hundreds,
   input  logic [7:0]  req_digit_tens,
   input  logic [7:0]  req_digit_units,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_port_b_value,
   output logic [7:0]  rsp_port_a_value,
   output logic        rsp_move_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   delays_type  delays_ff, delays_in;
   logic        queue_full;
   logic        push;
   item_type    push_item;
   logic        pop;
   logic        head_valid;
   item_type    head_item;

   // hold time registers
   assign csr_ready = 1'b1;

   always_comb begin
      delays_in = delays_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_G: delays_in.g = csr_wdata;
            CSR_DELAY_D: delays_in.d = csr_wdata;
            CSR_DELAY_K: delays_in.k = csr_wdata;
            default: delays_in = delays_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delays_ff.g <= DELAY_G_RESET;
         delays_ff.d <= DELAY_D_RESET;
         delays_ff.k <= DELAY_K_RESET;
      end else begin
         delays_ff <= delays_in;
      end
   end

   scs_front u_front (
      .req_valid           (req_valid),
      .req_command         (req_command),
      .req_motor_letter    (req_motor_letter),
      .req_direction_char  (req_direction_char),
      .req_digit_thousands (req_digit_thousands),
      .req_digit_hundreds  (req_digit_hundreds),
      .req_digit_tens      (req_digit_tens),
      .req_digit_units     (req_digit_units),
      .queue_full          (queue_full),
      .req_stall           (req_stall),
      .push                (push),
      .push_item           (push_item)
   );

   scs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   scs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .delays           (delays_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_port_b_value (rsp_port_b_value),
      .rsp_port_a_value (rsp_port_a_value),
      .rsp_move_done    (rsp_move_done)
   );

   // a move-end result always shows both ports cleared
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> rsp_port_b_value == 8'h00 && rsp_port_a_value == 8'h00)
      else $error("move end with a port still driven");

   // a step result always drives some coil
   a_step_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_move_done |-> rsp_port_b_value != 8'h00 || rsp_port_a_value != 8'h00)
      else $error("step result with no coil driven");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ----- design/scs_front.sv -----
`timescale 1ns / 1ps

module scs_front import scs_pkg::*; (
   input  logic        req_valid,
   input  logic        req_command,
   input  logic [7:0]  req_motor_letter,
   input  logic [7:0]  req_direction_char,
   input  logic [7:0]  req_digit_thousands,
   input  logic [7:0]  req_digit_hundreds,
   input  logic [7:0]  req_digit_tens,
   input  logic [7:0]  req_digit_units,
   input  logic        queue_full,
   output logic        req_stall,
   output logic        push,
   output item_type    push_item
);

   logic [7:0]          chars [4];
   logic [COUNT_W-1:0]  count;
   motor_type           motor;
   logic                letter_ok;
   logic                dir_ok;
   logic                packet_ok;

   assign chars[0] = req_digit_thousands;
   assign chars[1] = req_digit_hundreds;
   assign chars[2] = req_digit_tens;
   assign chars[3] = req_digit_units;

   // motor letter decode
   always_comb begin
      letter_ok = 1'b1;
      unique case (req_motor_letter)
         ASCII_G: motor = MOTOR_G;
         ASCII_D: motor = MOTOR_D;
         ASCII_K: motor = MOTOR_K;
         default: begin
            motor     = MOTOR_G;
            letter_ok = 1'b0;
         end
      endcase
   end

   assign dir_ok = (req_direction_char == ASCII_ONE) || (req_direction_char == ASCII_TWO);

   // decimal count, stops at the first non-digit
   always_comb begin
      logic stop;
      stop  = 1'b0;
      count = '0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (!stop) begin
            if (chars[i] >= ASCII_ZERO && chars[i] <= ASCII_NINE) begin
               count = COUNT_W'(count * COUNT_W'(10))
                     + {(COUNT_W-4)'(0), 4'(chars[i] - ASCII_ZERO)};
            end else begin
               stop = 1'b1;
            end
         end
      end
   end

   assign packet_ok = letter_ok && dir_ok && (32'(motor) < MOTOR_COUNT);

   // unknown packets are dropped here and never reach the queue
   assign req_stall         = queue_full;
   assign push              = req_valid && !queue_full && (!req_command || packet_ok);
   assign push_item.tick    = !req_command;
   assign push_item.motor   = motor;
   assign push_item.reverse = (req_direction_char == ASCII_TWO);
   assign push_item.count   = count;

endmodule

// ----- design/scs_queue.sv -----
`timescale 1ns / 1ps

module scs_queue import scs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output item_type  head_item
);

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/scs_back.sv -----
`timescale 1ns / 1ps

module scs_back import scs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head_item,
   input  delays_type  delays,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_port_b_value,
   output logic [7:0]  rsp_port_a_value,
   output logic        rsp_move_done
);

   logic [1:0]          phase_ff [MOTOR_COUNT];
   logic [1:0]          phase_in [MOTOR_COUNT];
   logic                busy_ff, busy_in;
   motor_type           active_ff, active_in;
   logic                reverse_ff, reverse_in;
   logic [COUNT_W-1:0]  steps_ff, steps_in;
   logic [DELAY_W-1:0]  ms_ff, ms_in;
   logic [7:0]          port_b_ff, port_b_in;
   logic [7:0]          port_a_ff, port_a_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                done_ff, done_in;

   motor_type           sel;
   logic                sel_rev;
   logic [1:0]          phase;
   logic [3:0]          pat;
   logic [DELAY_W-1:0]  hold;
   logic                out_ready;
   logic                do_step;
   logic                do_done;
   logic                do_dec;
   logic                do_start;
   logic                produce;

   // motor for the step: the running one on a tick, the new one on a start
   assign sel     = head_item.tick ? active_ff : head_item.motor;
   assign sel_rev = head_item.tick ? reverse_ff : head_item.reverse;

   always_comb begin
      logic [DELAY_W-1:0] d;
      unique case (sel)
         MOTOR_G: begin
            phase = phase_ff[0];
            d     = delays.g;
         end
         MOTOR_D: begin
            phase = phase_ff[1];
            d     = delays.d;
         end
         MOTOR_K: begin
            phase = phase_ff[2 % MOTOR_COUNT];
            d     = delays.k;
         end
         default: begin
            phase = phase_ff[0];
            d     = delays.g;
         end
      endcase
      hold = (d == '0) ? DELAY_W'(1) : d;
      pat  = step_base(sel_rev ? (2'd3 - phase) : phase);
   end

   // classify the head item against the current move state
   always_comb begin
      do_step  = 1'b0;
      do_done  = 1'b0;
      do_dec   = 1'b0;
      do_start = 1'b0;
      if (head_valid) begin
         if (head_item.tick) begin
            if (busy_ff) begin
               if (ms_ff > DELAY_W'(1)) begin
                  do_dec = 1'b1;
               end else if (steps_ff == '0) begin
                  do_done = 1'b1;
               end else begin
                  do_step = 1'b1;
               end
            end
         end else if (!busy_ff) begin
            if (head_item.count == '0) begin
               do_done = 1'b1;
            end else begin
               do_start = 1'b1;
               do_step  = 1'b1;
            end
         end
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign produce   = do_step || do_done;
   assign pop       = head_valid && (!produce || out_ready);

   // next state
   always_comb begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         phase_in[i] = phase_ff[i];
      end
      busy_in      = busy_ff;
      active_in    = active_ff;
      reverse_in   = reverse_ff;
      steps_in     = steps_ff;
      ms_in        = ms_ff;
      port_b_in    = port_b_ff;
      port_a_in    = port_a_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         if (do_dec) begin
            ms_in = ms_ff - 1'b1;
         end
         if (do_done) begin
            busy_in      = 1'b0;
            ms_in        = '0;
            port_b_in    = PORT_CLEAR;
            port_a_in    = PORT_CLEAR;
            done_in      = 1'b1;
            rsp_valid_in = 1'b1;
         end
         if (do_start) begin
            busy_in    = 1'b1;
            active_in  = head_item.motor;
            reverse_in = head_item.reverse;
            steps_in   = head_item.count - 1'b1;
         end else if (do_step) begin
            steps_in = steps_ff - 1'b1;
         end
         if (do_step) begin
            unique case (sel)
               MOTOR_D: port_b_in = {pat, 4'h0};
               MOTOR_K: port_a_in = {4'h0, pat};
               default: port_b_in = {4'h0, pat};
            endcase
            for (int i = 0; i < MOTOR_COUNT; i++) begin
               if (32'(sel) == i) begin
                  phase_in[i] = phase + 1'b1;
               end
            end
            ms_in        = hold;
            done_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            phase_ff[i] <= '0;
         end
         busy_ff      <= 1'b0;
         active_ff    <= MOTOR_G;
         reverse_ff   <= 1'b0;
         steps_ff     <= '0;
         ms_ff        <= '0;
         port_b_ff    <= PORT_CLEAR;
         port_a_ff    <= PORT_CLEAR;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            phase_ff[i] <= phase_in[i];
         end
         busy_ff      <= busy_in;
         active_ff    <= active_in;
         reverse_ff   <= reverse_in;
         steps_ff     <= steps_in;
         ms_ff        <= ms_in;
         port_b_ff    <= port_b_in;
         port_a_ff    <= port_a_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // port registers change only when a result is loaded, so they are the payload
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_port_b_value = port_b_ff;
   assign rsp_port_a_value = port_a_ff;
   assign rsp_move_done    = done_ff;

endmodule
